// ===== hdl/cnm_pkg.sv =====
// Shared types, constants and coefficient tables of the complex NCO mixer.
`timescale 1ns / 1ps

package cnm_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W = 16;
  localparam int TRIG_W   = 16;
  localparam int PHASE_W  = 20;
  localparam int FREQ_W   = 20;
  localparam int OCT_W    = PHASE_W + 3;
  localparam int FRAC_W   = 30;
  localparam int DVD_W    = 50;
  localparam int PROD_W   = 64;
  localparam int MUL_W    = 32;

  // Phase modulus and fixed-point constants
  localparam logic [PHASE_W-1:0] PHASE_MOD      = 20'd1000000;
  localparam logic [FRAC_W-1:0]  QUARTER_PI_Q30 = 30'd843314857;
  localparam logic [FRAC_W:0]    Q30_ONE        = 31'h4000_0000;
  localparam logic [TRIG_W-2:0]  TRIG_AMP       = '1;
  localparam logic [PROD_W-1:0]  HALF_Q30       = 64'h0000_0000_2000_0000;
  localparam logic [PROD_W-1:0]  TWO_POW_32     = 64'h0000_0001_0000_0000;

  // Angle division by the modulus: floor(2^50 / modulus) on the top 32 dividend bits
  localparam logic [MUL_W-1:0]   MOD_RECIP      = 32'd1125899906;
  localparam logic [DVD_W-1:0]   MOD_X1         = 50'd1000000;
  localparam logic [DVD_W-1:0]   MOD_X2         = 50'd2000000;

  // Horner evaluation: six sine terms, then six cosine terms
  localparam int HORNER_N  = 12;
  localparam int SIN_TERMS = 6;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // Request operation codes
  localparam logic OP_MIX   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic [PHASE_W-1:0]         phase;
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
  } cnm_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cnm_q_status_t;

  typedef enum logic [4:0] {
    B_IDLE,
    B_OCT,
    B_XMUL,
    B_XREC,
    B_XCHK,
    B_XFIX,
    B_X2,
    B_HMUL,
    B_HREC,
    B_HCHK,
    B_HFIX,
    B_SIN,
    B_SCS,
    B_SCC,
    B_QUAD,
    B_MA,
    B_MB,
    B_MC,
    B_OUT
  } cnm_back_state_t;

  // Divisor of each Horner term
  function automatic logic [7:0] horner_div(input logic [3:0] j);
    case (j)
      4'd0:    horner_div = 8'd156;
      4'd1:    horner_div = 8'd110;
      4'd2:    horner_div = 8'd72;
      4'd3:    horner_div = 8'd42;
      4'd4:    horner_div = 8'd20;
      4'd5:    horner_div = 8'd6;
      4'd6:    horner_div = 8'd132;
      4'd7:    horner_div = 8'd90;
      4'd8:    horner_div = 8'd56;
      4'd9:    horner_div = 8'd30;
      4'd10:   horner_div = 8'd12;
      4'd11:   horner_div = 8'd2;
      default: horner_div = 8'd1;
    endcase
  endfunction

  // floor(2^32 / divisor) of each Horner term
  function automatic logic [MUL_W-1:0] horner_recip(input logic [3:0] j);
    case (j)
      4'd0:    horner_recip = MUL_W'(TWO_POW_32 / 64'd156);
      4'd1:    horner_recip = MUL_W'(TWO_POW_32 / 64'd110);
      4'd2:    horner_recip = MUL_W'(TWO_POW_32 / 64'd72);
      4'd3:    horner_recip = MUL_W'(TWO_POW_32 / 64'd42);
      4'd4:    horner_recip = MUL_W'(TWO_POW_32 / 64'd20);
      4'd5:    horner_recip = MUL_W'(TWO_POW_32 / 64'd6);
      4'd6:    horner_recip = MUL_W'(TWO_POW_32 / 64'd132);
      4'd7:    horner_recip = MUL_W'(TWO_POW_32 / 64'd90);
      4'd8:    horner_recip = MUL_W'(TWO_POW_32 / 64'd56);
      4'd9:    horner_recip = MUL_W'(TWO_POW_32 / 64'd30);
      4'd10:   horner_recip = MUL_W'(TWO_POW_32 / 64'd12);
      4'd11:   horner_recip = MUL_W'(TWO_POW_32 / 64'd2);
      default: horner_recip = '1;
    endcase
  endfunction

  // k * modulus, the start of octant k in eighth-phase units
  function automatic logic [OCT_W-1:0] oct_base(input logic [2:0] k);
    oct_base = OCT_W'(k) * OCT_W'(PHASE_MOD);
  endfunction

endpackage

// ===== hdl/cnm_front.sv =====
// Front end: accepts requests, holds the frequency word and phase index, queues samples.
`timescale 1ns / 1ps

module cnm_front import cnm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [FREQ_W-1:0]          cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  logic signed [SAMPLE_W-1:0] in_real,
  input  logic signed [SAMPLE_W-1:0] in_imag,
  input  cnm_q_status_t              q_status,
  output logic                       q_push,
  output cnm_item_t                  q_item
);

  logic [FREQ_W-1:0]  freq_r;
  logic [PHASE_W-1:0] phase_r;
  logic [PHASE_W-1:0] phase_nxt;
  logic [PHASE_W-1:0] step;
  logic [PHASE_W:0]   phase_sum;
  logic               accept;

  // Stall only while the queue is full
  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;
  assign q_push   = accept && (in_op == OP_MIX);

  assign q_item.phase = phase_r;
  assign q_item.re    = in_real;
  assign q_item.im    = in_imag;

  // Reduce the frequency word once; it stays below twice the modulus
  always_comb begin
    if (freq_r >= PHASE_MOD) begin
      step = freq_r - PHASE_MOD;
    end else begin
      step = freq_r;
    end
    phase_sum = {1'b0, phase_r} + {1'b0, step};
    if (phase_sum >= {1'b0, PHASE_MOD}) begin
      phase_nxt = PHASE_W'(phase_sum - {1'b0, PHASE_MOD});
    end else begin
      phase_nxt = phase_sum[PHASE_W-1:0];
    end
  end

  // Write config, clear or advance the phase per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r  <= '0;
      phase_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        freq_r <= cfg_wr_data;
      end
      if (accept) begin
        if (in_op == OP_CLEAR) begin
          phase_r <= '0;
        end else begin
          phase_r <= phase_nxt;
        end
      end
    end
  end

endmodule

// ===== hdl/cnm_queue.sv =====
// Short FIFO that decouples the front end from the back end.
`timescale 1ns / 1ps

module cnm_queue import cnm_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cnm_item_t     push_item,
  input  logic          pop,
  output cnm_item_t     head_item,
  output cnm_q_status_t status
);

  cnm_item_t         entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic [QPTR_W:0]   count_nxt;

  assign status.full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign head_item    = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hdl/cnm_back.sv =====
// Back end: sequencer that computes cos/sin of the phase and mixes the sample.
`timescale 1ns / 1ps

module cnm_back import cnm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cnm_q_status_t              q_status,
  input  cnm_item_t                  q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_real,
  output logic signed [SAMPLE_W-1:0] out_imag
);

  cnm_back_state_t state_r, state_nxt;

  logic [PHASE_W-1:0]         p_r, p_nxt;
  logic signed [SAMPLE_W-1:0] re_r, re_nxt;
  logic signed [SAMPLE_W-1:0] im_r, im_nxt;
  logic [PHASE_W-1:0]         r_r, r_nxt;
  logic [1:0]                 quad_r, quad_nxt;
  logic                       neg_r, neg_nxt;
  logic [DVD_W-1:0]           dvd_r, dvd_nxt;
  logic [DVD_W-1:0]           xqd_r, xqd_nxt;
  logic [FRAC_W-1:0]          x_r, x_nxt;
  logic [FRAC_W-1:0]          x2_r, x2_nxt;
  logic [FRAC_W:0]            h_r, h_nxt;
  logic [FRAC_W-1:0]          t_r, t_nxt;
  logic [FRAC_W-1:0]          q0_r, q0_nxt;
  logic [FRAC_W-1:0]          qd_r, qd_nxt;
  logic [3:0]                 j_r, j_nxt;
  logic [FRAC_W-1:0]          s_r, s_nxt;
  logic [TRIG_W-2:0]          si_r, si_nxt;
  logic [TRIG_W-2:0]          ci_r, ci_nxt;
  logic signed [TRIG_W-1:0]   cs_r, cs_nxt;
  logic signed [TRIG_W-1:0]   sn_r, sn_nxt;
  logic signed [2*SAMPLE_W-1:0] pa_r, pa_nxt;
  logic signed [2*SAMPLE_W-1:0] pb_r, pb_nxt;
  logic signed [2*SAMPLE_W:0]   accr_r, accr_nxt;
  logic signed [2*SAMPLE_W:0]   acci_r, acci_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_real_r, out_real_nxt;
  logic signed [SAMPLE_W-1:0] out_imag_r, out_imag_nxt;

  // Shared unsigned multiplier
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;

  // Sample multipliers
  logic signed [SAMPLE_W-1:0]   ma_a, mb_a;
  logic signed [TRIG_W-1:0]     ma_b, mb_b;
  logic signed [2*SAMPLE_W-1:0] ma_p, mb_p;

  // Octant reduction
  logic [OCT_W-1:0]   p8;
  logic [OCT_W-1:0]   r_full;
  logic [2:0]         oct;
  logic [3:0]         oct_inc;

  // Quotient corrections
  logic [DVD_W-1:0]   xrem;
  logic [FRAC_W-1:0]  xfix;
  logic [FRAC_W-1:0]  hrem;
  logic [FRAC_W-1:0]  qfix;
  logic [PROD_W-1:0]  scaled;
  logic signed [TRIG_W-1:0] si_e, ci_e;
  logic               out_free;

  assign out_valid = out_valid_r;
  assign out_real  = out_real_r;
  assign out_imag  = out_imag_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Round half up at bit 15, then saturate to the sample range
  function automatic logic signed [SAMPLE_W-1:0] round_sat(
    input logic signed [2*SAMPLE_W:0] acc
  );
    logic signed [2*SAMPLE_W+1:0] biased;
    logic signed [SAMPLE_W+2:0]   v;
    biased = {acc[2*SAMPLE_W], acc} + 34'sd16384;
    v      = biased[2*SAMPLE_W+1:TRIG_W-1];
    if (v > 19'sd32767) begin
      round_sat = 16'sh7fff;
    end else if (v < -19'sd32768) begin
      round_sat = 16'sh8000;
    end else begin
      round_sat = v[SAMPLE_W-1:0];
    end
  endfunction

  // Select shared multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      B_XMUL: begin
        mul_a = MUL_W'(r_r);
        mul_b = MUL_W'(QUARTER_PI_Q30);
      end
      B_XREC: begin
        mul_a = dvd_r[DVD_W-1:DVD_W-MUL_W];
        mul_b = MOD_RECIP;
      end
      B_XCHK: begin
        mul_a = MUL_W'(q0_r);
        mul_b = MUL_W'(PHASE_MOD);
      end
      B_X2: begin
        mul_a = MUL_W'(x_r);
        mul_b = MUL_W'(x_r);
      end
      B_HMUL: begin
        mul_a = MUL_W'(x2_r);
        mul_b = MUL_W'(h_r);
      end
      B_HREC: begin
        mul_a = MUL_W'(t_r);
        mul_b = horner_recip(j_r);
      end
      B_HCHK: begin
        mul_a = MUL_W'(q0_r);
        mul_b = MUL_W'(horner_div(j_r));
      end
      B_SIN: begin
        mul_a = MUL_W'(x_r);
        mul_b = MUL_W'(h_r);
      end
      B_SCS: begin
        mul_a = MUL_W'(s_r);
        mul_b = MUL_W'(TRIG_AMP);
      end
      B_SCC: begin
        mul_a = MUL_W'(h_r);
        mul_b = MUL_W'(TRIG_AMP);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Select sample multiplier operands
  always_comb begin
    if (state_r == B_MB) begin
      ma_a = re_r;
      ma_b = sn_r;
      mb_a = im_r;
      mb_b = cs_r;
    end else begin
      ma_a = re_r;
      ma_b = cs_r;
      mb_a = im_r;
      mb_b = sn_r;
    end
  end

  assign ma_p = ma_a * ma_b;
  assign mb_p = mb_a * mb_b;

  // Find the octant of the phase and the folded remainder
  always_comb begin
    p8  = {p_r, 3'b000};
    oct = 3'd0;
    for (int k = 1; k < 8; k++) begin
      if (p8 >= oct_base(3'(k))) begin
        oct = 3'(k);
      end
    end
    r_full  = p8 - oct_base(oct);
    oct_inc = {1'b0, oct} + 4'd1;
  end

  // Quotient corrections for the angle and the Horner terms
  always_comb begin
    xrem   = dvd_r - xqd_r;
    xfix   = q0_r + FRAC_W'(xrem >= MOD_X1) + FRAC_W'(xrem >= MOD_X2);
    hrem   = t_r - qd_r;
    qfix   = q0_r + FRAC_W'(hrem >= FRAC_W'(horner_div(j_r)));
    scaled = mul_p + HALF_Q30;
    si_e   = neg_r ? -$signed({1'b0, si_r}) : $signed({1'b0, si_r});
    ci_e   = $signed({1'b0, ci_r});
  end

  // Next state and datapath updates
  always_comb begin
    state_nxt     = state_r;
    p_nxt         = p_r;
    re_nxt        = re_r;
    im_nxt        = im_r;
    r_nxt         = r_r;
    quad_nxt      = quad_r;
    neg_nxt       = neg_r;
    dvd_nxt       = dvd_r;
    xqd_nxt       = xqd_r;
    x_nxt         = x_r;
    x2_nxt        = x2_r;
    h_nxt         = h_r;
    t_nxt         = t_r;
    q0_nxt        = q0_r;
    qd_nxt        = qd_r;
    j_nxt         = j_r;
    s_nxt         = s_r;
    si_nxt        = si_r;
    ci_nxt        = ci_r;
    cs_nxt        = cs_r;
    sn_nxt        = sn_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    accr_nxt      = accr_r;
    acci_nxt      = acci_r;
    out_real_nxt  = out_real_r;
    out_imag_nxt  = out_imag_r;
    out_valid_nxt = out_valid_r && out_stall;
    q_pop         = 1'b0;

    case (state_r)
      // Take the next sample from the queue
      B_IDLE: begin
        if (!q_status.empty) begin
          q_pop     = 1'b1;
          p_nxt     = q_head.phase;
          re_nxt    = q_head.re;
          im_nxt    = q_head.im;
          state_nxt = B_OCT;
        end
      end
      // Fold the phase into the first octant
      B_OCT: begin
        if (oct[0]) begin
          r_nxt    = PHASE_MOD - r_full[PHASE_W-1:0];
          quad_nxt = oct_inc[2:1];
          neg_nxt  = 1'b1;
        end else begin
          r_nxt    = r_full[PHASE_W-1:0];
          quad_nxt = oct[2:1];
          neg_nxt  = 1'b0;
        end
        state_nxt = B_XMUL;
      end
      // Scale the remainder by pi/4 before dividing by the modulus
      B_XMUL: begin
        dvd_nxt   = mul_p[DVD_W-1:0];
        state_nxt = B_XREC;
      end
      // Angle quotient estimate by reciprocal, at most two below the true one
      B_XREC: begin
        q0_nxt    = mul_p[FRAC_W+MUL_W-1:MUL_W];
        state_nxt = B_XCHK;
      end
      B_XCHK: begin
        xqd_nxt   = mul_p[DVD_W-1:0];
        state_nxt = B_XFIX;
      end
      // Correct the angle estimate from the remainder
      B_XFIX: begin
        x_nxt     = xfix;
        state_nxt = B_X2;
      end
      // Square the angle and start the sine series
      B_X2: begin
        x2_nxt    = mul_p[2*FRAC_W-1:FRAC_W];
        h_nxt     = Q30_ONE;
        j_nxt     = '0;
        state_nxt = B_HMUL;
      end
      B_HMUL: begin
        t_nxt     = mul_p[2*FRAC_W-1:FRAC_W];
        state_nxt = B_HREC;
      end
      // Quotient estimate by reciprocal
      B_HREC: begin
        q0_nxt    = mul_p[FRAC_W+MUL_W-1:MUL_W];
        state_nxt = B_HCHK;
      end
      B_HCHK: begin
        qd_nxt    = mul_p[FRAC_W-1:0];
        state_nxt = B_HFIX;
      end
      // Correct the estimate by one and close the Horner term
      B_HFIX: begin
        h_nxt = Q30_ONE - {1'b0, qfix};
        j_nxt = j_r + 1'b1;
        if (j_r == 4'(SIN_TERMS-1)) begin
          state_nxt = B_SIN;
        end else if (j_r == 4'(HORNER_N-1)) begin
          state_nxt = B_SCS;
        end else begin
          state_nxt = B_HMUL;
        end
      end
      // Finish the sine and start the cosine series
      B_SIN: begin
        s_nxt     = mul_p[2*FRAC_W-1:FRAC_W];
        h_nxt     = Q30_ONE;
        state_nxt = B_HMUL;
      end
      // Scale sine and cosine to the trig amplitude
      B_SCS: begin
        si_nxt    = scaled[FRAC_W+TRIG_W-2:FRAC_W];
        state_nxt = B_SCC;
      end
      B_SCC: begin
        ci_nxt    = scaled[FRAC_W+TRIG_W-2:FRAC_W];
        state_nxt = B_QUAD;
      end
      // Map to the quadrant
      B_QUAD: begin
        case (quad_r)
          2'd0: begin
            sn_nxt = si_e;
            cs_nxt = ci_e;
          end
          2'd1: begin
            sn_nxt = ci_e;
            cs_nxt = -si_e;
          end
          2'd2: begin
            sn_nxt = -si_e;
            cs_nxt = -ci_e;
          end
          default: begin
            sn_nxt = -ci_e;
            cs_nxt = si_e;
          end
        endcase
        state_nxt = B_MA;
      end
      // Complex multiply
      B_MA: begin
        pa_nxt    = ma_p;
        pb_nxt    = mb_p;
        state_nxt = B_MB;
      end
      B_MB: begin
        accr_nxt  = {pa_r[2*SAMPLE_W-1], pa_r} - {pb_r[2*SAMPLE_W-1], pb_r};
        pa_nxt    = ma_p;
        pb_nxt    = mb_p;
        state_nxt = B_MC;
      end
      B_MC: begin
        acci_nxt  = {pa_r[2*SAMPLE_W-1], pa_r} + {pb_r[2*SAMPLE_W-1], pb_r};
        state_nxt = B_OUT;
      end
      // Hold until the output register is free
      B_OUT: begin
        if (out_free) begin
          out_real_nxt  = round_sat(accr_r);
          out_imag_nxt  = round_sat(acci_r);
          out_valid_nxt = 1'b1;
          state_nxt     = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    re_r       <= re_nxt;
    im_r       <= im_nxt;
    r_r        <= r_nxt;
    quad_r     <= quad_nxt;
    neg_r      <= neg_nxt;
    dvd_r      <= dvd_nxt;
    xqd_r      <= xqd_nxt;
    x_r        <= x_nxt;
    x2_r       <= x2_nxt;
    h_r        <= h_nxt;
    t_r        <= t_nxt;
    q0_r       <= q0_nxt;
    qd_r       <= qd_nxt;
    j_r        <= j_nxt;
    s_r        <= s_nxt;
    si_r       <= si_nxt;
    ci_r       <= ci_nxt;
    cs_r       <= cs_nxt;
    sn_r       <= sn_nxt;
    pa_r       <= pa_nxt;
    pb_r       <= pb_nxt;
    accr_r     <= accr_nxt;
    acci_r     <= acci_nxt;
    out_real_r <= out_real_nxt;
    out_imag_r <= out_imag_nxt;
  end

endmodule

// ===== hdl/complex_nco_mixer_unit.sv =====
// Top level of the complex NCO mixer: front end, queue and mixing back end.
//
// Usage:
//   cfg_wr_en/cfg_wr_data write the 20-bit frequency word (phase step per
//   mixed sample, reduced modulo one million). Write it while the block idles.
//   The input channel (in_valid/in_stall) takes one request per accepted edge:
//   in_op = 0 mixes in_real/in_imag with e^(j*2*pi*p/1e6), in_op = 1 clears
//   the phase index and gives no result. The front end tracks the phase
//   and queues up to four samples, so it keeps accepting while the back
//   end works; in_stall rises only when the queue is full.
//   The back end works on one sample at a time: a reciprocal multiply and
//   a correction divide the scaled octant remainder by the modulus,
//   then one shared 32x32 multiplier runs twelve Horner terms
//   plus scaling and the complex multiply. It takes the next sample from
//   the queue only after the current result enters the output register.
//   A finished result waits in the output register while out_stall is high;
//   the back end holds its next result until that register is taken.
//   Synchronous reset (rst_n low) clears the phase index, the frequency
//   word, the queue and out_valid.
`timescale 1ns / 1ps

module complex_nco_mixer_unit import cnm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [FREQ_W-1:0]          cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  logic signed [SAMPLE_W-1:0] in_real,
  input  logic signed [SAMPLE_W-1:0] in_imag,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_real,
  output logic signed [SAMPLE_W-1:0] out_imag
);

  cnm_q_status_t q_status;
  logic          q_push;
  logic          q_pop;
  cnm_item_t     q_item;
  cnm_item_t     q_head;

  cnm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_real     (in_real),
    .in_imag     (in_imag),
    .q_status    (q_status),
    .q_push      (q_push),
    .q_item      (q_item)
  );

  cnm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head_item (q_head),
    .status    (q_status)
  );

  cnm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_real  (out_real),
    .out_imag  (out_imag)
  );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for complex_nco_mixer_unit: directed table, random phases, predictor.
`timescale 1ns / 1ps

module testbench;
  import cnm_pkg::*;

  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int SETTLE_CYCLES   = 120;
  localparam int N_DIRECTED      = 25;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int MAX_REPORTS     = 10;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

  localparam longint unsigned Q30_UNIT   = 64'd1 << 30;
  localparam longint unsigned PI4_Q30    = 64'd843314857;
  localparam longint unsigned PHASE_L    = 64'd1000000;
  localparam int unsigned     PHASE_SPAN = 1000000;
  localparam longint unsigned TRIG_PEAK  = (64'd1 << (TRIG_W - 1)) - 64'd1;
  localparam longint          SAT_HI     = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;
  localparam longint          SAT_LO     = -SAT_HI - 64'sd1;

  typedef enum logic [1:0] {ROW_MIX, ROW_CLEAR, ROW_TUNE} stim_kind_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
  } mix_sample_t;

  typedef struct packed {
    stim_kind_t                 kind;
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    logic [FREQ_W-1:0]          freq;
    logic                       typed;
    logic signed [SAMPLE_W-1:0] exp_re;
    logic signed [SAMPLE_W-1:0] exp_im;
  } stim_row_t;

  // Directed requests: corners at phase zero, a full turn in 45 degree steps, clears,
  // the largest register value and a step that wraps the phase on every sample
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_MIX,   S_MAX,        S_MIN,        20'd0,       1'b1, 16'sd32766,   -16'sd32767},
    '{ROW_MIX,   S_MIN,        S_MAX,        20'd0,       1'b1, -16'sd32767,  16'sd32766},
    '{ROW_MIX,   16'sd0,       16'sd0,       20'd0,       1'b1, 16'sd0,       16'sd0},
    '{ROW_MIX,   S_MIN,        S_MIN,        20'd0,       1'b1, -16'sd32767,  -16'sd32767},
    '{ROW_MIX,   16'sd1,       -16'sd1,      20'd0,       1'b0, 16'sd0,       16'sd0},
    '{ROW_CLEAR, 16'sd12345,   -16'sd1,      20'd0,       1'b0, 16'sd0,       16'sd0},
    '{ROW_TUNE,  16'sd0,       16'sd0,       20'd125000,  1'b0, 16'sd0,       16'sd0},
    '{ROW_MIX,   S_MAX,        S_MAX,        20'd0,       1'b0, 16'sd0,       16'sd0},
    '{ROW_MIX,   S_MIN,        S_MAX,        20'd0,       1'b0, 16'sd0,       16'sd0},
    '{ROW_MIX,   S_MAX,        S_MIN,        20'd0,       1'b0, 16'sd0,       16'sd0},
    '{ROW_MIX,   S_MIN,        S_MIN,        20'd0,       1'b0, 16'sd0,       16'sd0},
    '{ROW_MIX,   S_MAX,        S_MAX,        20'd0,       1'b0, 16'sd0,       16'sd0},
    '{ROW_MIX,   S_MIN,        S_MAX,        20'd0,       1'b0, 16'sd0,       16'sd0},
    '{ROW_MIX,   S_MAX,        S_MIN,        20'd0,       1'b0, 16'sd0,       16'sd0},
    '{ROW_MIX,   S_MIN,        S_MIN,        20'd0,       1'b0, 16'sd0,       16'sd0},
    '{ROW_MIX,   S_MAX,        16'sd0,       20'd0,       1'b0, 16'sd0,       16'sd0},
    '{ROW_CLEAR, S_MIN,        S_MAX,        20'd0,       1'b0, 16'sd0,       16'sd0},
    '{ROW_MIX,   S_MIN,        S_MAX,        20'd0,       1'b0, 16'sd0,       16'sd0},
    '{ROW_TUNE,  16'sd0,       16'sd0,       20'hFFFFF,   1'b0, 16'sd0,       16'sd0},
    '{ROW_MIX,   16'sd12345,   -16'sd23456,  20'd0,       1'b0, 16'sd0,       16'sd0},
    '{ROW_MIX,   -16'sd1,      16'sd1,       20'd0,       1'b0, 16'sd0,       16'sd0},
    '{ROW_TUNE,  16'sd0,       16'sd0,       20'd999999,  1'b0, 16'sd0,       16'sd0},
    '{ROW_MIX,   S_MAX,        S_MIN,        20'd0,       1'b0, 16'sd0,       16'sd0},
    '{ROW_MIX,   S_MIN,        S_MAX,        20'd0,       1'b0, 16'sd0,       16'sd0},
    '{ROW_MIX,   16'sd16384,   -16'sd16384,  20'd0,       1'b0, 16'sd0,       16'sd0}
  };

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [FREQ_W-1:0]          cfg_wr_data;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_op;
  logic signed [SAMPLE_W-1:0] in_real;
  logic signed [SAMPLE_W-1:0] in_imag;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] out_real;
  logic signed [SAMPLE_W-1:0] out_imag;

  // Predictor state and the results still owed by the block
  int unsigned       nco_phase;
  logic [FREQ_W-1:0] nco_freq;
  mix_sample_t       mix_expected [$];
  int                error_count;
  int                tx_max_gap;
  int                rx_max_stall;
  int                idle_cycles;

  complex_nco_mixer_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_real    (in_real),
    .in_imag    (in_imag),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_real   (out_real),
    .out_imag   (out_imag)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One Horner term in Q30: 1 - x2 * h / d
  function automatic longint unsigned horner_step(input longint unsigned x2,
                                                  input longint unsigned h,
                                                  input longint unsigned d);
    return Q30_UNIT - ((x2 * h) >> 30) / d;
  endfunction

  // Sine and cosine in Q30 of an angle in the first octant
  function automatic void octant_sincos(input longint unsigned x,
                                        output longint unsigned s,
                                        output longint unsigned c);
    longint unsigned x2;
    longint unsigned h;
    x2 = (x * x) >> 30;
    h = Q30_UNIT;
    h = horner_step(x2, h, 156);
    h = horner_step(x2, h, 110);
    h = horner_step(x2, h, 72);
    h = horner_step(x2, h, 42);
    h = horner_step(x2, h, 20);
    h = horner_step(x2, h, 6);
    s = (x * h) >> 30;
    h = Q30_UNIT;
    h = horner_step(x2, h, 132);
    h = horner_step(x2, h, 90);
    h = horner_step(x2, h, 56);
    h = horner_step(x2, h, 30);
    h = horner_step(x2, h, 12);
    h = horner_step(x2, h, 2);
    c = h;
  endfunction

  function automatic longint trig_scale(input longint unsigned v);
    return longint'((v * TRIG_PEAK + (64'd1 << 29)) >> 30);
  endfunction

  // Fold the phase into one octant, evaluate, then unfold by quadrant
  function automatic void phase_to_trig(input int unsigned p, output longint cs,
                                        output longint sn);
    longint unsigned p8;
    longint unsigned octant;
    longint unsigned rem;
    longint unsigned quad;
    longint unsigned s;
    longint unsigned c;
    longint          si;
    longint          ci;
    p8 = longint'(p) * 64'd8;
    octant = p8 / PHASE_L;
    rem = p8 - octant * PHASE_L;
    if (octant[0]) begin
      rem = PHASE_L - rem;
      quad = (octant + 64'd1) / 64'd2;
    end else begin
      quad = octant / 64'd2;
    end
    octant_sincos((rem * PI4_Q30) / PHASE_L, s, c);
    si = trig_scale(s);
    ci = trig_scale(c);
    if (octant[0]) si = -si;
    case (quad[1:0])
      2'd0: begin
        sn = si;  cs = ci;
      end
      2'd1: begin
        sn = ci;  cs = -si;
      end
      2'd2: begin
        sn = -si; cs = -ci;
      end
      default: begin
        sn = -ci; cs = si;
      end
    endcase
  endfunction

  // Round half up at the trig scale, then clamp to the sample range
  function automatic logic signed [SAMPLE_W-1:0] round_saturate(input longint acc);
    longint v;
    v = (acc + (64'sd1 <<< (TRIG_W - 2))) >>> (TRIG_W - 1);
    if (v > SAT_HI) v = SAT_HI;
    else if (v < SAT_LO) v = SAT_LO;
    return SAMPLE_W'(v);
  endfunction

  function automatic mix_sample_t mix_at_phase(input int unsigned p,
                                               input logic signed [SAMPLE_W-1:0] re,
                                               input logic signed [SAMPLE_W-1:0] im);
    longint      cs;
    longint      sn;
    longint      xr;
    longint      xi;
    mix_sample_t r;
    phase_to_trig(p, cs, sn);
    xr = longint'(re);
    xi = longint'(im);
    r.re = round_saturate(xr * cs - xi * sn);
    r.im = round_saturate(xr * sn + xi * cs);
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(0, 7))
      0: return S_MAX;
      1: return S_MIN;
      2: return 16'sd0;
      3: return -16'sd1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Hold the request until it is taken, then advance the predictor
  task automatic push_request(input logic op, input logic signed [SAMPLE_W-1:0] re,
                              input logic signed [SAMPLE_W-1:0] im, input int gap,
                              input logic typed, input mix_sample_t typed_res);
    mix_sample_t res;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_real  <= re;
    in_imag  <= im;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_CLEAR) begin
      nco_phase = 0;
    end else begin
      res = mix_at_phase(nco_phase, re, im);
      mix_expected.push_back(typed ? typed_res : res);
      nco_phase = nco_phase + int'(nco_freq) % PHASE_SPAN;
      if (nco_phase >= PHASE_SPAN) nco_phase = nco_phase - PHASE_SPAN;
    end
    @(negedge clk);
  endtask

  // Drop valid and hold until every owed result has come, then settle
  task automatic wait_for_results(input int settle);
    in_valid <= 1'b0;
    do @(negedge clk); while (mix_expected.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic tune_nco(input logic [FREQ_W-1:0] value);
    wait_for_results(SETTLE_CYCLES);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    nco_freq = value;
  endtask

  // Stimulus
  initial begin
    mix_sample_t typed_res;
    logic [FREQ_W-1:0] freq;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_valid     = 1'b0;
    in_op        = OP_MIX;
    in_real      = '0;
    in_imag      = '0;
    nco_phase    = 0;
    nco_freq     = '0;
    error_count  = 0;
    tx_max_gap   = 11;
    rx_max_stall = 11;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table
    foreach (directed_rows[i]) begin
      typed_res = {directed_rows[i].exp_re, directed_rows[i].exp_im};
      case (directed_rows[i].kind)
        ROW_TUNE:  tune_nco(directed_rows[i].freq);
        ROW_CLEAR: push_request(OP_CLEAR, directed_rows[i].re, directed_rows[i].im,
                                $urandom_range(0, tx_max_gap), 1'b0, typed_res);
        default:   push_request(OP_MIX, directed_rows[i].re, directed_rows[i].im,
                                $urandom_range(0, tx_max_gap), directed_rows[i].typed,
                                typed_res);
      endcase
    end

    // Random phases, each with its own frequency word and idling pattern
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: freq = 20'd0;
        1: freq = 20'd999999;
        2: freq = 20'hFFFFF;
        3: freq = 20'd1;
        4: freq = 20'd250000;
        5: freq = FREQ_W'($urandom_range(0, 999999));
        default: freq = FREQ_W'($urandom);
      endcase
      tune_nco(freq);
      tx_max_gap   = (ph % 3 == 0) ? 0 : 11;
      rx_max_stall = (ph % 2 == 0) ? 0 : 11;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(0, 59) == 0) wait_for_results(0);
        if ($urandom_range(0, 11) == 0)
          push_request(OP_CLEAR, draw_sample(), draw_sample(),
                       $urandom_range(0, tx_max_gap), 1'b0, '0);
        else
          push_request(OP_MIX, draw_sample(), draw_sample(),
                       $urandom_range(0, tx_max_gap), 1'b0, '0);
      end
    end

    wait_for_results(SETTLE_CYCLES);
    if (error_count == 0 && mix_expected.size() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  // Result side: stall at random, take each result and compare with the oldest expectation
  initial begin
    int          stall;
    mix_sample_t want;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = $urandom_range(0, rx_max_stall);
      if (stall > 0) begin
        out_stall <= 1'b1;
        repeat (stall) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (mix_expected.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected result: got (%0d, %0d)", out_real, out_imag);
      end else begin
        want = mix_expected.pop_front();
        if (out_real !== want.re || out_imag !== want.im) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("mismatch: expected (%0d, %0d) got (%0d, %0d)",
                     want.re, want.im, out_real, out_imag);
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog: end the run if no request moves on either channel for too long
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

endmodule

// ===== filelist.f =====
hdl/cnm_pkg.sv
hdl/cnm_front.sv
hdl/cnm_queue.sv
hdl/cnm_back.sv
hdl/complex_nco_mixer_unit.sv
verif/testbench.sv
